// ===== rtl/bcdmux_pkg.sv =====
// Shared types and constants for the binary to BCD digit multiplexer.
package bcdmux_pkg;

    localparam int VALUE_W        = 32;
    localparam int DIGIT_W        = 4;
    localparam int COUNT_W        = 4;
    // Four binary bits are shifted into the BCD register per conversion cycle.
    localparam int BITS_PER_STEP  = 4;
    localparam int CONV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(CONV_STEPS);
    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 4'd3;

    typedef struct packed {
        logic load;       // capture a new value and start the conversion
        logic conv_step;  // run one double-dabble step
        logic emit;       // move the next digit into the output register
    } cmd_t;

    typedef struct packed {
        logic conv_last;  // the current step is the final conversion step
        logic digit_last; // the next digit to emit is the final one
    } status_t;

endpackage

// ===== rtl/binary_to_bcd_digit_mux.sv =====
// Top level of the binary to BCD digit multiplexer for a latched decimal display.
// Input channel: value with in_valid / in_stall. An item is taken at a rising edge
// where in_valid is high and in_stall is low. Output channel: bcd_digit,
// digit_position and last with out_valid / out_stall; a digit is taken at an edge
// where out_valid is high and out_stall is low.
// Each item gives one result per shown digit, most significant shown digit first
// at position 0; last marks the final digit. Digits above the shown count are dropped.
// cfg_write loads cfg_data into the digit count; zero acts as one and values above
// MAX_DIGITS act as MAX_DIGITS. Write it only while the block is idle.
// After acceptance the shift-add-3 converter takes in four bits of the value per cycle
// until all of them are in; then the shown digits enter the output register one at a
// time, each one as soon as the output register is empty or being drained.
// One item is worked on at a time; in_stall is high from acceptance until the final
// digit has entered the output register, so the next item is taken while that digit
// still waits. When the receiver stalls, the output register holds its digit and
// digit output pauses. Reset empties the output and sets the digit count to three.
module binary_to_bcd_digit_mux
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bcdmux_pkg::COUNT_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bcdmux_pkg::VALUE_W-1:0]      value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bcdmux_pkg::DIGIT_W-1:0]      bcd_digit,
    output logic [bcdmux_pkg::COUNT_W-1:0]      digit_position,
    output logic                                last
);

    bcdmux_pkg::cmd_t    cmd;
    bcdmux_pkg::status_t status;

    bcdmux_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bcdmux_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .value          (value),
        .cmd            (cmd),
        .status         (status),
        .bcd_digit      (bcd_digit),
        .digit_position (digit_position),
        .last           (last)
    );

endmodule

// ===== rtl/bcdmux_ctrl.sv =====
// Controller state machine: accepts items, sequences conversion and digit output.
module bcdmux_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  bcdmux_pkg::status_t status,
    output bcdmux_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a digit when empty or being drained now.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.digit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/bcdmux_datapath.sv =====
// Datapath: digit count register, shift-add-3 converter and digit output register.
module bcdmux_datapath
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [bcdmux_pkg::COUNT_W-1:0]          cfg_data,
    input  logic [bcdmux_pkg::VALUE_W-1:0]          value,
    input  bcdmux_pkg::cmd_t                        cmd,
    output bcdmux_pkg::status_t                     status,
    output logic [bcdmux_pkg::DIGIT_W-1:0]          bcd_digit,
    output logic [bcdmux_pkg::COUNT_W-1:0]          digit_position,
    output logic                                    last
);

    localparam int BCD_W = MAX_DIGITS * bcdmux_pkg::DIGIT_W;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [bcdmux_pkg::COUNT_W-1:0] MAX_COUNT = bcdmux_pkg::COUNT_W'(MAX_DIGITS);

    logic [bcdmux_pkg::COUNT_W-1:0] digit_count_reg;
    logic [bcdmux_pkg::VALUE_W-1:0] bin_reg;
    logic [bcdmux_pkg::VALUE_W-1:0] bin_next;
    logic [BCD_W-1:0]               bcd_reg;
    logic [BCD_W-1:0]               bcd_next;
    logic [bcdmux_pkg::STEP_W-1:0]  step_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [bcdmux_pkg::COUNT_W-1:0] pos_reg;
    logic [bcdmux_pkg::DIGIT_W-1:0] bcd_digit_reg;
    logic [bcdmux_pkg::COUNT_W-1:0] digit_position_reg;
    logic                           last_reg;
    logic [bcdmux_pkg::COUNT_W-1:0] count_m1;

    // A count of zero shows one digit; counts above the maximum saturate.
    always_comb
    begin
        priority if (digit_count_reg == '0)
        begin
            count_m1 = '0;
        end
        else if (digit_count_reg > MAX_COUNT)
        begin
            count_m1 = MAX_COUNT - 4'd1;
        end
        else
        begin
            count_m1 = digit_count_reg - 4'd1;
        end
    end

    // Four double-dabble iterations per cycle. Digits above the register are
    // lost, which leaves the value modulo ten to the power of MAX_DIGITS.
    always_comb
    begin
        logic [BCD_W-1:0]               b;
        logic [bcdmux_pkg::VALUE_W-1:0] v;
        b = bcd_reg;
        v = bin_reg;
        for (int s = 0; s < bcdmux_pkg::BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (b[d*4 +: 4] >= 4'd5)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], v[bcdmux_pkg::VALUE_W-1]};
            v = {v[bcdmux_pkg::VALUE_W-2:0], 1'b0};
        end
        bcd_next = b;
        bin_next = v;
    end

    assign status.conv_last  = (step_reg == bcdmux_pkg::STEP_W'(bcdmux_pkg::CONV_STEPS - 1));
    assign status.digit_last = (idx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= bcdmux_pkg::DIGIT_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            digit_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg  <= value;
            bcd_reg  <= '0;
            step_reg <= '0;
            idx_reg  <= IDX_W'(count_m1);
            pos_reg  <= '0;
        end
        if (cmd.conv_step)
        begin
            bin_reg  <= bin_next;
            bcd_reg  <= bcd_next;
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            bcd_digit_reg      <= bcd_reg[idx_reg*4 +: 4];
            digit_position_reg <= pos_reg;
            last_reg           <= (idx_reg == '0);
            idx_reg            <= idx_reg - 1'b1;
            pos_reg            <= pos_reg + 4'd1;
        end
    end

    assign bcd_digit      = bcd_digit_reg;
    assign digit_position = digit_position_reg;
    assign last           = last_reg;

endmodule
